[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that cond implies nxt in the next cycle.
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

[hdl/wvft_pkg.sv]
package wvft_pkg;

  localparam int TABLE_DEPTH = 256;
  // count must hold TABLE_DEPTH itself
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  // width for position compares against count and the 8-bit read index
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  localparam logic signed [47:0] ONE_Q16 = 48'sh0000_0001_0000;
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_RD_OK   = 3'd3,
    ST_RD_OOR  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] key_value;
    logic signed [31:0] weight_value;
    logic [7:0]         read_index;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] entry_key;
    logic signed [47:0] entry_sum;
    logic [8:0]         entry_total;
  } out_rsp_t;

  // request travelling down the cell row, with its result once resolved
  typedef struct packed {
    logic               active;
    op_t                op;
    logic signed [31:0] key;
    logic signed [47:0] weight;
    logic [7:0]         idx;
    logic               done;
    status_t            status;
    logic signed [31:0] res_key;
    logic signed [47:0] res_sum;
  } probe_t;

endpackage

[hdl/weighted_value_frequency_table_core.sv]
// Weighted distinct-value frequency table.
// Request channel: present in_req and raise start; the request is taken at
// an edge where start is high and busy is low. Accumulate adds the weight to
// the entry holding key_value, or appends a new entry; read returns the entry
// at read_index; clear empties the table.
// Result channel: out_valid strobes for one cycle with out_rsp; the receiver
// cannot stall, so every result must be taken on that cycle.
// Config: cfg_data[0] is use_weights (0 = each item weighs 1.0); cfg_ready is
// always high, writes are expected only while the block is idle.
// Flow: accumulate and read walk a row of TABLE_DEPTH cells, one cell per
// cycle; out_valid rises once the request has left the last cell, and the
// result is taken at the edge that ends the strobe. busy drops with the
// strobe and the next request is taken at the edge that ends it, so no new
// request enters while one is in the row. Clear and the unused opcode strobe
// in the cycle right after accept and are taken at the next edge, so they
// can follow each other back to back.
// Reset (rst_n low, synchronous): table count and use_weights go to zero;
// stored keys and sums are left as they are and read only below the count.
module weighted_value_frequency_table_core
  import wvft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

`include "assert_macros.svh"

  logic             use_weights_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  logic             accept;
  probe_t           inj;
  probe_t           last;
  probe_t           chain_in  [TABLE_DEPTH];
  probe_t           chain_out [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] act_vec;
  logic             new_rsp;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // Request entering cell 0; weight resolved here so the cells only add or store it.
  always_comb begin
    inj        = '0;
    inj.op     = in_req.operation;
    inj.key    = in_req.key_value;
    inj.idx    = in_req.read_index;
    inj.weight = use_weights_r ? {{16{in_req.weight_value[31]}}, in_req.weight_value}
                               : ONE_Q16;
    inj.status = ST_RD_OOR;
    case (in_req.operation)
      OP_ACC, OP_READ: inj.active = accept;
      default:         inj.active = 1'b0;
    endcase
  end

  // Cell row: each cell owns one table slot and passes the request on.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = inj;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    wvft_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_pos (CMP_W'(i)),
      .count    (count_r),
      .prb_in   (chain_in[i]),
      .prb_out  (chain_out[i])
    );
    assign act_vec[i] = chain_out[i].active;
  end

  assign last = chain_out[TABLE_DEPTH-1];

  // Result formation: request leaving the row, or a clear or unused opcode.
  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    if (last.active) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (last.done) begin
        out_rsp_nxt.status    = last.status;
        out_rsp_nxt.entry_key = last.res_key;
        out_rsp_nxt.entry_sum = last.res_sum;
        if (last.status == ST_NEW) begin
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end else begin
        // nobody claimed it: table full (every read index has a cell)
        case (last.op)
          OP_ACC: begin
            out_rsp_nxt.status    = ST_FULL;
            out_rsp_nxt.entry_key = last.key;
          end
          default: begin
            out_rsp_nxt.status    = ST_RD_OOR;
            out_rsp_nxt.entry_key = '0;
          end
        endcase
        out_rsp_nxt.entry_sum = '0;
      end
      out_rsp_nxt.entry_total = 9'(count_nxt);
    end else if (accept) begin
      case (in_req.operation)
        OP_ACC, OP_READ: begin
          busy_nxt = 1'b1;
        end
        OP_CLEAR: begin
          count_nxt               = '0;
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = ST_CLEARED;
          out_rsp_nxt.entry_key   = '0;
          out_rsp_nxt.entry_sum   = '0;
          out_rsp_nxt.entry_total = '0;
        end
        default: begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = ST_RD_OOR;
          out_rsp_nxt.entry_key   = '0;
          out_rsp_nxt.entry_sum   = '0;
          out_rsp_nxt.entry_total = 9'(count_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    if (!rst_n) begin
      use_weights_r <= 1'b0;
      count_r       <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        use_weights_r <= cfg_data;
      end
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign new_rsp = out_valid_r && (out_rsp_r.status == ST_NEW);

  `ASSERT_CLK(a_one_probe, $onehot0(act_vec), "more than one request in the cell row")
  `ASSERT_CLK(a_cnt_bound, count_r <= CNT_FULL, "entry count beyond table depth")
  `ASSERT_CLK(a_rsp_idle, out_valid_r |-> !busy_r, "result strobed while still busy")
  `ASSERT_NEXT(a_accept, accept, busy_r || out_valid_r, "accepted request went nowhere")
  `ASSERT_CLK(a_new_cnt, new_rsp |-> (count_r == CNT_W'($past(count_r) + 1'b1)), "count step")

endmodule

[hdl/wvft_cell.sv]
module wvft_cell
  import wvft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMP_W-1:0] cell_pos,
  input  logic [CNT_W-1:0] count,
  input  probe_t           prb_in,
  output probe_t           prb_out
);

  logic signed [31:0] key_r, key_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  probe_t             prb_r, prb_nxt;

  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   idx_ext;
  logic               occupied;
  logic               live;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_sat;

  assign cnt_ext  = CMP_W'(count);
  assign idx_ext  = CMP_W'(prb_in.idx);
  assign occupied = cell_pos < cnt_ext;
  assign live     = prb_in.active && !prb_in.done;

  // saturating Q32.16 add
  assign sum_wide = {sum_r[47], sum_r} + {prb_in.weight[47], prb_in.weight};
  always_comb begin
    if (sum_wide[48] != sum_wide[47]) begin
      sum_sat = sum_wide[48] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[47:0];
    end
  end

  always_comb begin
    key_nxt = key_r;
    sum_nxt = sum_r;
    prb_nxt = prb_in;
    if (live) begin
      case (prb_in.op)
        OP_ACC: begin
          if (occupied && (key_r == prb_in.key)) begin
            sum_nxt         = sum_sat;
            prb_nxt.done    = 1'b1;
            prb_nxt.status  = ST_ADDED;
            prb_nxt.res_key = key_r;
            prb_nxt.res_sum = sum_sat;
          end else if (cell_pos == cnt_ext) begin
            // first free slot: append
            key_nxt         = prb_in.key;
            sum_nxt         = prb_in.weight;
            prb_nxt.done    = 1'b1;
            prb_nxt.status  = ST_NEW;
            prb_nxt.res_key = prb_in.key;
            prb_nxt.res_sum = prb_in.weight;
          end
        end
        OP_READ: begin
          if (cell_pos == idx_ext) begin
            prb_nxt.done = 1'b1;
            if (occupied) begin
              prb_nxt.status  = ST_RD_OK;
              prb_nxt.res_key = key_r;
              prb_nxt.res_sum = sum_r;
            end else begin
              prb_nxt.status  = ST_RD_OOR;
              prb_nxt.res_key = '0;
              prb_nxt.res_sum = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    sum_r <= sum_nxt;
    if (!rst_n) begin
      prb_r <= '0;
    end else begin
      prb_r <= prb_nxt;
    end
  end

  assign prb_out = prb_r;

endmodule
